>>> rtl/assert_macros.svh
// Assertion helpers for the lexer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check, clocked and disabled during reset.
`define AST_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication check.
`define AST_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/stl_pkg.sv
//------------------------------------------------------------------------------
// stl_pkg
// Shared types, codes and keyword table for the source text lexer.
//------------------------------------------------------------------------------
`default_nettype none
package stl_pkg;
    localparam int MAX_LEN     = 256;
    localparam int OFFSET_BITS = 16;
    localparam int LEN_BITS    = $clog2(MAX_LEN + 1);
    localparam int WORD_KEEP   = 10;
    localparam int NUM_KW      = 14;

    localparam logic [2:0] K_KEYWORD = 3'd0;
    localparam logic [2:0] K_IDENT   = 3'd1;
    localparam logic [2:0] K_NUMBER  = 3'd2;
    localparam logic [2:0] K_STRING  = 3'd3;
    localparam logic [2:0] K_OPER    = 3'd4;
    localparam logic [2:0] K_ERROR   = 3'd5;
    localparam logic [2:0] K_END     = 3'd6;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_UNKNOWN = 3'd1;
    localparam logic [2:0] E_COMMENT = 3'd2;
    localparam logic [2:0] E_STRING  = 3'd3;
    localparam logic [2:0] E_LONG    = 3'd4;

    localparam logic [4:0] OP_PLUS_GT  = 5'd15;
    localparam logic [4:0] OP_MINUS_GT = 5'd16;
    localparam logic [4:0] OP_STAR_GT  = 5'd17;
    localparam logic [4:0] OP_SLASH_GT = 5'd18;
    localparam logic [4:0] OP_POW      = 5'd19;

    // character class from the front end
    typedef enum logic [2:0] {
        C_SPACE, C_ALPHA, C_DIGIT, C_QUOTE, C_OPER, C_OTHER
    } t_cls;

    typedef struct packed {
        logic [7:0]             ch;
        logic                   last;
        t_cls                   cls;
        logic                   under;
        logic [4:0]             op;
        logic [OFFSET_BITS-1:0] off;
    } t_item;

    typedef struct packed {
        logic [2:0]             kind;
        logic [3:0]             kw;
        logic [4:0]             op;
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]    len;
        logic [2:0]             err;
        logic                   last;
    } t_rec;

    typedef logic [WORD_KEEP*8-1:0] t_word;

    function automatic t_word kw_word(input int k);
        case (k)
            0:  kw_word = {"let",        56'd0};
            1:  kw_word = {"set",        56'd0};
            2:  kw_word = {"check",      40'd0};
            3:  kw_word = "othercheck";
            4:  kw_word = {"other",      40'd0};
            5:  kw_word = {"echo",       48'd0};
            6:  kw_word = {"loop",       48'd0};
            7:  kw_word = {"stop",       48'd0};
            8:  kw_word = {"funcdo",     32'd0};
            9:  kw_word = {"done",       48'd0};
            10: kw_word = {"run",        56'd0};
            11: kw_word = {"catch",      40'd0};
            12: kw_word = {"module",     32'd0};
            default: kw_word = {"return", 32'd0};
        endcase
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        case (k)
            0, 1, 10:          kw_len = 4'd3;
            2, 4, 11:          kw_len = 4'd5;
            3:                 kw_len = 4'd10;
            5, 6, 7, 9:        kw_len = 4'd4;
            default:           kw_len = 4'd6;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> rtl/stl_front.sv
//------------------------------------------------------------------------------
// stl_front
// Accepts bytes, classifies them, tags offsets and fills a two-entry queue.
//------------------------------------------------------------------------------
`default_nettype none
module stl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_source_byte,
    input  wire logic          i_final_byte,
    output logic               o_q_valid,
    output stl_pkg::t_item     o_q_item,
    input  wire logic          i_q_pop
);
    logic [stl_pkg::OFFSET_BITS-1:0] r_off;
    stl_pkg::t_item r_q [2];
    logic [1:0] r_cnt;
    logic r_rd, r_wr;
    stl_pkg::t_item w_item;
    logic w_push;

    always_comb begin
        w_item       = '0;
        w_item.ch    = i_source_byte;
        w_item.last  = i_final_byte;
        w_item.off   = r_off;
        w_item.under = (i_source_byte == 8'h5f);
        w_item.cls   = stl_pkg::C_OTHER;
        case (i_source_byte) inside
            8'd32, [8'd9:8'd13]:       w_item.cls = stl_pkg::C_SPACE;
            ["a":"z"], ["A":"Z"]:      w_item.cls = stl_pkg::C_ALPHA;
            ["0":"9"]:                 w_item.cls = stl_pkg::C_DIGIT;
            8'h22:                     w_item.cls = stl_pkg::C_QUOTE;
            "=", "+", "-", ">", "*", "/", ",", "{", "}", ":", ";", "(", ")", "[", "]":
                w_item.cls = stl_pkg::C_OPER;
            default:                   w_item.cls = stl_pkg::C_OTHER;
        endcase
        case (i_source_byte)
            "=": w_item.op = 5'd0;   "+": w_item.op = 5'd1;
            "-": w_item.op = 5'd2;   ">": w_item.op = 5'd3;
            "*": w_item.op = 5'd4;   "/": w_item.op = 5'd5;
            ",": w_item.op = 5'd6;   "{": w_item.op = 5'd7;
            "}": w_item.op = 5'd8;   ":": w_item.op = 5'd9;
            ";": w_item.op = 5'd10;  "(": w_item.op = 5'd11;
            ")": w_item.op = 5'd12;  "[": w_item.op = 5'd13;
            "]": w_item.op = 5'd14;
            default: w_item.op = 5'd0;
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_item;
                r_wr      <= !r_wr;
                r_off     <= i_final_byte ? '0 : r_off + 1'b1;
            end
            if (i_q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/stl_back.sv
//------------------------------------------------------------------------------
// stl_back
// Lexer state machine; emits up to three records per byte, one per cycle while not stalled.
//------------------------------------------------------------------------------
`default_nettype none
module stl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  stl_pkg::t_item     i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    output stl_pkg::t_rec      o_rec,
    input  wire logic          i_stall
);
    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUMBER, M_SLASH, M_OPSEEN, M_LINE,
        M_BLOCK, M_BLOCK_STAR, M_STRING, M_ERROR
    } t_mode;

    localparam int LB = stl_pkg::LEN_BITS;
    localparam int OB = stl_pkg::OFFSET_BITS;
    localparam logic [LB-1:0] MAXL = LB'(stl_pkg::MAX_LEN);

    t_mode r_mode, n_mode;
    stl_pkg::t_word r_word, n_word;
    logic [OB-1:0] r_start, n_start;
    logic [LB-1:0] r_len, n_len;
    logic [4:0] r_pend, n_pend;
    logic [7:0] r_pch, n_pch;
    // records for the current byte, drained one per cycle unless the output is stalled
    stl_pkg::t_rec r_buf [3];
    logic [1:0] r_nbuf, r_ibuf;
    logic r_ov;
    stl_pkg::t_rec r_out;

    stl_pkg::t_rec w_r [3];
    logic [1:0] w_n;
    logic w_out_free, w_busy;
    stl_pkg::t_item it;
    logic [OB-1:0] w_next_off;

    function automatic stl_pkg::t_rec mk(input logic [2:0] k, input logic [3:0] kw,
            input logic [4:0] op, input logic [OB-1:0] s, input logic [LB-1:0] l,
            input logic [2:0] e);
        stl_pkg::t_rec r;
        r.kind = k; r.kw = kw; r.op = op; r.start = s; r.len = l; r.err = e;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic stl_pkg::t_rec word_rec(input stl_pkg::t_word w,
            input logic [OB-1:0] s, input logic [LB-1:0] l);
        stl_pkg::t_rec r;
        r = mk(stl_pkg::K_IDENT, 4'd0, 5'd0, s, l, stl_pkg::E_NONE);
        for (int k = stl_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (l == LB'(stl_pkg::kw_len(k)) && w == stl_pkg::kw_word(k)) begin
                r.kind = stl_pkg::K_KEYWORD;
                r.kw   = 4'(k);
            end
        end
        return r;
    endfunction

    assign it         = i_q_item;
    assign w_busy     = (r_ibuf != r_nbuf);
    assign w_out_free = !r_ov || !i_stall;
    assign o_q_pop    = i_q_valid && !w_busy;
    assign w_next_off = it.off + 1'b1;

    always_comb begin
        logic idle_go;
        n_mode = r_mode; n_word = r_word; n_start = r_start; n_len = r_len;
        n_pend = r_pend; n_pch = r_pch;
        w_r[0] = '0; w_r[1] = '0; w_r[2] = '0;
        w_n = 2'd0;
        idle_go = 1'b0;
        case (r_mode)
            M_WORD: begin
                if (it.cls == stl_pkg::C_ALPHA || it.cls == stl_pkg::C_DIGIT || it.under) begin
                    if (r_len >= MAXL) begin
                        w_r[w_n] = mk(stl_pkg::K_ERROR, 4'd0, 5'd0, r_start, '0,
                                      stl_pkg::E_LONG);
                        w_n = w_n + 2'd1; n_mode = M_ERROR;
                    end else begin
                        if (r_len < LB'(stl_pkg::WORD_KEEP))
                            n_word[8*(stl_pkg::WORD_KEEP-1-32'(r_len)) +: 8] = it.ch;
                        n_len = r_len + 1'b1;
                    end
                end else begin
                    w_r[w_n] = word_rec(r_word, r_start, r_len);
                    w_n = w_n + 2'd1; idle_go = 1'b1;
                end
            end
            M_NUMBER: begin
                if (it.cls == stl_pkg::C_DIGIT || it.ch == ".") begin
                    if (r_len >= MAXL) begin
                        w_r[w_n] = mk(stl_pkg::K_ERROR, 4'd0, 5'd0, r_start, '0,
                                      stl_pkg::E_LONG);
                        w_n = w_n + 2'd1; n_mode = M_ERROR;
                    end else n_len = r_len + 1'b1;
                end else begin
                    w_r[w_n] = mk(stl_pkg::K_NUMBER, 4'd0, 5'd0, r_start, r_len,
                                  stl_pkg::E_NONE);
                    w_n = w_n + 2'd1; idle_go = 1'b1;
                end
            end
            M_SLASH: begin
                if (it.ch == "/") n_mode = M_LINE;
                else if (it.ch == "*") n_mode = M_BLOCK;
                else if (it.ch == ">") begin
                    w_r[w_n] = mk(stl_pkg::K_OPER, 4'd0, stl_pkg::OP_SLASH_GT, r_start,
                                  LB'(2), stl_pkg::E_NONE);
                    w_n = w_n + 2'd1; n_mode = M_IDLE;
                end else begin
                    w_r[w_n] = mk(stl_pkg::K_OPER, 4'd0, 5'd5, r_start, LB'(1),
                                  stl_pkg::E_NONE);
                    w_n = w_n + 2'd1; idle_go = 1'b1;
                end
            end
            M_OPSEEN: begin
                if (it.ch == ">") begin
                    w_r[w_n] = mk(stl_pkg::K_OPER, 4'd0,
                                  r_pch == "+" ? stl_pkg::OP_PLUS_GT :
                                  r_pch == "-" ? stl_pkg::OP_MINUS_GT : stl_pkg::OP_STAR_GT,
                                  r_start, LB'(2), stl_pkg::E_NONE);
                    w_n = w_n + 2'd1; n_mode = M_IDLE;
                end else if (r_pch == "*" && it.ch == "*") begin
                    w_r[w_n] = mk(stl_pkg::K_OPER, 4'd0, stl_pkg::OP_POW, r_start,
                                  LB'(2), stl_pkg::E_NONE);
                    w_n = w_n + 2'd1; n_mode = M_IDLE;
                end else begin
                    w_r[w_n] = mk(stl_pkg::K_OPER, 4'd0, r_pend, r_start, LB'(1),
                                  stl_pkg::E_NONE);
                    w_n = w_n + 2'd1; idle_go = 1'b1;
                end
            end
            M_LINE:       if (it.ch == 8'h0a) n_mode = M_IDLE;
            M_BLOCK:      if (it.ch == "*") n_mode = M_BLOCK_STAR;
            M_BLOCK_STAR: begin
                if (it.ch == "/") n_mode = M_IDLE;
                else if (it.ch != "*") n_mode = M_BLOCK;
            end
            M_STRING: begin
                if (it.cls == stl_pkg::C_QUOTE) begin
                    w_r[w_n] = mk(stl_pkg::K_STRING, 4'd0, 5'd0, r_start, r_len,
                                  stl_pkg::E_NONE);
                    w_n = w_n + 2'd1; n_mode = M_IDLE;
                end else if (r_len >= MAXL) begin
                    w_r[w_n] = mk(stl_pkg::K_ERROR, 4'd0, 5'd0, r_start, '0,
                                  stl_pkg::E_LONG);
                    w_n = w_n + 2'd1; n_mode = M_ERROR;
                end else n_len = r_len + 1'b1;
            end
            M_ERROR: ;
            default: idle_go = 1'b1;
        endcase
        if (idle_go) begin
            n_mode = M_IDLE;
            case (it.cls)
                stl_pkg::C_SPACE: ;
                stl_pkg::C_ALPHA: begin
                    n_word = '0;
                    n_word[8*stl_pkg::WORD_KEEP-1 -: 8] = it.ch;
                    n_start = it.off; n_len = LB'(1); n_mode = M_WORD;
                end
                stl_pkg::C_DIGIT: begin
                    n_start = it.off; n_len = LB'(1); n_mode = M_NUMBER;
                end
                stl_pkg::C_QUOTE: begin
                    n_start = w_next_off; n_len = '0; n_mode = M_STRING;
                end
                stl_pkg::C_OPER: begin
                    if (it.ch == "/") begin
                        n_start = it.off; n_mode = M_SLASH;
                    end else if (it.ch == "+" || it.ch == "-" || it.ch == "*") begin
                        n_pch = it.ch; n_pend = it.op; n_start = it.off;
                        n_mode = M_OPSEEN;
                    end else begin
                        w_r[w_n] = mk(stl_pkg::K_OPER, 4'd0, it.op, it.off, LB'(1),
                                      stl_pkg::E_NONE);
                        w_n = w_n + 2'd1;
                    end
                end
                default: begin
                    w_r[w_n] = mk(stl_pkg::K_ERROR, 4'd0, 5'd0, it.off, '0,
                                  stl_pkg::E_UNKNOWN);
                    w_n = w_n + 2'd1; n_mode = M_ERROR;
                end
            endcase
        end
        if (it.last) begin
            case (n_mode)
                M_WORD: begin
                    w_r[w_n] = word_rec(n_word, n_start, n_len); w_n = w_n + 2'd1;
                end
                M_NUMBER: begin
                    w_r[w_n] = mk(stl_pkg::K_NUMBER, 4'd0, 5'd0, n_start, n_len,
                                  stl_pkg::E_NONE);
                    w_n = w_n + 2'd1;
                end
                M_SLASH: begin
                    w_r[w_n] = mk(stl_pkg::K_OPER, 4'd0, 5'd5, n_start, LB'(1),
                                  stl_pkg::E_NONE);
                    w_n = w_n + 2'd1;
                end
                M_OPSEEN: begin
                    w_r[w_n] = mk(stl_pkg::K_OPER, 4'd0, n_pend, n_start, LB'(1),
                                  stl_pkg::E_NONE);
                    w_n = w_n + 2'd1;
                end
                M_BLOCK, M_BLOCK_STAR: begin
                    w_r[w_n] = mk(stl_pkg::K_ERROR, 4'd0, 5'd0, n_start, '0,
                                  stl_pkg::E_COMMENT);
                    w_n = w_n + 2'd1;
                end
                M_STRING: begin
                    w_r[w_n] = mk(stl_pkg::K_ERROR, 4'd0, 5'd0, n_start, '0,
                                  stl_pkg::E_STRING);
                    w_n = w_n + 2'd1;
                end
                default: ;
            endcase
            w_r[w_n] = mk(stl_pkg::K_END, 4'd0, 5'd0, w_next_off, '0, stl_pkg::E_NONE);
            w_n = w_n + 2'd1;
            n_mode = M_IDLE; n_word = '0; n_start = '0; n_len = '0;
            n_pend = '0; n_pch = '0;
        end
        if (w_n != 2'd0) w_r[w_n - 2'd1].last = 1'b1;
    end

    assign o_valid = r_ov;
    assign o_rec   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_word <= '0; r_start <= '0; r_len <= '0;
            r_pend <= '0; r_pch <= '0;
            r_nbuf <= '0; r_ibuf <= '0; r_ov <= 1'b0;
        end else begin
            // output slot refills from the buffer whenever it frees up
            if (w_out_free) r_ov <= w_busy;
            if (w_busy) begin
                if (w_out_free) begin
                    r_out  <= r_buf[r_ibuf];
                    r_ibuf <= r_ibuf + 2'd1;
                end
            end else if (o_q_pop) begin
                r_mode <= n_mode; r_word <= n_word; r_start <= n_start;
                r_len <= n_len; r_pend <= n_pend; r_pch <= n_pch;
                r_buf[0] <= w_r[0]; r_buf[1] <= w_r[1]; r_buf[2] <= w_r[2];
                r_nbuf <= w_n;
                r_ibuf <= 2'd0;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/source_text_lexer.sv
//------------------------------------------------------------------------------
// source_text_lexer
// Streaming tokenizer: source bytes in, token records out.
//------------------------------------------------------------------------------
// Input channel: one source byte per request with a final-byte flag; accepted
// when i_valid is high and o_stall is low. Output channel: one token record
// per request; taken when o_valid is high and i_stall is low.
// A front end classifies each byte and tags its offset into a two-entry
// queue; the back end runs the lexer state machine on one byte, buffers the
// zero to three records that byte causes and drains them one per cycle,
// while the receiver does not stall, through a registered output stage.
// A record passes the queue entry, the record buffer and the output register
// before it shows. The back end takes one byte per cycle while bytes yield no
// record; a byte with records holds the back end until they are drained.
// o_run_last marks the final record a byte caused; the final byte always
// ends with an end-of-input record.
// Reset (synchronous, active low) empties the queue and output stage and
// returns the lexer to idle at offset 0. A stalled receiver holds the output
// record steady; the queue then fills and o_stall rises.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module source_text_lexer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_final_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_token_kind,
    output logic [3:0]       o_keyword_number,
    output logic [4:0]       o_operator_code,
    output logic [15:0]      o_token_start,
    output logic [8:0]       o_token_length,
    output logic [2:0]       o_error_code,
    output logic             o_run_last
);
    logic           w_q_valid, w_q_pop;
    stl_pkg::t_item w_q_item;
    stl_pkg::t_rec  w_rec;

    stl_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_source_byte, .i_final_byte,
        .o_q_valid(w_q_valid), .o_q_item(w_q_item), .i_q_pop(w_q_pop)
    );

    stl_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_q_valid), .i_q_item(w_q_item),
        .o_q_pop(w_q_pop), .o_valid, .o_rec(w_rec), .i_stall
    );

    assign o_token_kind     = w_rec.kind;
    assign o_keyword_number = w_rec.kw;
    assign o_operator_code  = w_rec.op;
    assign o_token_start    = w_rec.start;
    assign o_token_length   = w_rec.len;
    assign o_error_code     = w_rec.err;
    assign o_run_last       = w_rec.last;

    // queue never pops while empty
    `AST_IMP(a_pop_nonempty, i_clk, i_rst_n, w_q_pop, w_q_valid)
    // a stalled record stays in place
    `AST_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(w_rec))
    // end records always close a byte's run
    `AST_IMP(a_end_last, i_clk, i_rst_n, o_valid && o_token_kind == stl_pkg::K_END,
             o_run_last)
endmodule
`default_nettype wire
